@@ src/ntpss_pkg.sv @@
// shared types and constants for the ntp sync sequencer
`timescale 1ns / 1ps

package ntpss_pkg;

	// ntp era starts 1900, unix era 1970
	localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

	// n / 1000 == (n * ceil(2^38 / 1000)) >> 38 for every 32-bit n
	localparam int          MS_RECIP_W     = 29;
	localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;
	localparam int          MS_RECIP_SHIFT = 38;
	localparam int          MS_PROD_W      = 32 + MS_RECIP_W;
	localparam int          SECS_W         = MS_PROD_W - MS_RECIP_SHIFT;

	localparam int          CFG_INDEX_W    = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SYNC_ENABLE       = 3'd0,
		REG_RESYNC_INTERVAL   = 3'd1,
		REG_MAX_TRIES         = 3'd2,
		REG_FIRST_KICK_GAP    = 3'd3,
		REG_RESEND_GAP        = 3'd4
	} cfg_reg_t;

	localparam logic        RST_SYNC_ENABLE     = 1'b0;
	localparam logic [31:0] RST_RESYNC_INTERVAL = 32'd3600000;
	localparam logic [7:0]  RST_MAX_TRIES       = 8'd3;
	localparam logic [15:0] RST_FIRST_KICK_GAP  = 16'd50;
	localparam logic [15:0] RST_RESEND_GAP      = 16'd400;

	typedef struct packed {
		logic        sync_enable;
		logic [31:0] resync_period_ms;
		logic [7:0]  try_limit;
		logic [15:0] first_kick_gap_ms;
		logic [15:0] resend_gap_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic [SECS_W-1:0] secs;
		logic [31:0]       next_tick;
	} tick_info_t;

	typedef struct packed {
		logic        send_request;
		logic [31:0] epoch_utc;
		logic        time_valid;
		logic        synced;
		logic        gave_up;
		logic        bogus_reply;
	} result_t;

endpackage

@@ src/ntpss_cfg.sv @@
// configuration register file for the ntp sync sequencer
`timescale 1ns / 1ps

module ntpss_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ntpss_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                         cfg_data,
	output ntpss_pkg::cfg_regs_t                regs
);

	ntpss_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_enable        <= ntpss_pkg::RST_SYNC_ENABLE;
			regs_q.resync_period_ms   <= ntpss_pkg::RST_RESYNC_INTERVAL;
			regs_q.try_limit          <= ntpss_pkg::RST_MAX_TRIES;
			regs_q.first_kick_gap_ms  <= ntpss_pkg::RST_FIRST_KICK_GAP;
			regs_q.resend_gap_ms      <= ntpss_pkg::RST_RESEND_GAP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ntpss_pkg::REG_SYNC_ENABLE:     regs_q.sync_enable        <= cfg_data[0];
				ntpss_pkg::REG_RESYNC_INTERVAL: regs_q.resync_period_ms   <= cfg_data;
				ntpss_pkg::REG_MAX_TRIES:       regs_q.try_limit          <= cfg_data[7:0];
				ntpss_pkg::REG_FIRST_KICK_GAP:  regs_q.first_kick_gap_ms  <= cfg_data[15:0];
				ntpss_pkg::REG_RESEND_GAP:      regs_q.resend_gap_ms      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/ntpss_tick.sv @@
// whole-second tick: elapsed ms split into seconds and the advanced tick mark
`timescale 1ns / 1ps

module ntpss_tick (
	input  logic [31:0]            now_ms,
	input  logic [31:0]            last_tick,
	output ntpss_pkg::tick_info_t  tick
);

	logic [31:0]                      delta;
	logic [ntpss_pkg::MS_PROD_W-1:0]  prod;
	logic [ntpss_pkg::SECS_W-1:0]     secs;
	logic [31:0]                      secs_w;
	logic [31:0]                      whole_ms;

	always_comb begin
		delta    = now_ms - last_tick;
		// reciprocal multiply, exact over the whole 32-bit range
		prod     = ntpss_pkg::MS_PROD_W'(delta) * ntpss_pkg::MS_PROD_W'(ntpss_pkg::MS_RECIP);
		secs     = prod[ntpss_pkg::MS_PROD_W-1:ntpss_pkg::MS_RECIP_SHIFT];
		secs_w   = 32'(secs);
		// secs * 1000 as 1024 - 16 - 8
		whole_ms = (secs_w << 10) - (secs_w << 4) - (secs_w << 3);
		tick.secs      = secs;
		tick.next_tick = last_tick + whole_ms;
	end

endmodule

@@ src/ntpss_seq.sv @@
// sync sequencer state and per-poll decision logic
`timescale 1ns / 1ps

module ntpss_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [31:0]            now_ms,
	input  logic                   reply_valid,
	input  logic [31:0]            reply_ntp_seconds,
	input  ntpss_pkg::cfg_regs_t   regs,
	input  ntpss_pkg::tick_info_t  tick,
	output logic [31:0]            last_tick,
	output ntpss_pkg::result_t     result
);

	logic [31:0] epoch_q;
	logic        have_time_q;
	logic [31:0] last_tick_q;
	logic [31:0] last_sync_q;
	logic [31:0] last_kick_q;
	logic [7:0]  try_q;

	logic [31:0] epoch_t;
	logic        due;
	logic        first_kick;
	logic        reply_ok;
	logic        after_first;
	logic        resend_chk;
	logic        resend;
	logic        give_up;
	logic        sync_ok;
	logic [31:0] epoch_n;
	logic        have_n;
	logic [31:0] tick_n;
	logic [31:0] sync_n;
	logic [31:0] kick_n;
	logic [7:0]  try_n;

	assign last_tick = last_tick_q;

	always_comb begin
		epoch_t     = have_time_q ? epoch_q + 32'(tick.secs) : epoch_q;
		due         = regs.sync_enable &&
			(!have_time_q || (now_ms - last_sync_q) >= regs.resync_period_ms);
		first_kick  = (try_q == 8'd0) &&
			((now_ms - last_kick_q) >= 32'(regs.first_kick_gap_ms));
		reply_ok    = reply_ntp_seconds >= ntpss_pkg::NTP_UNIX_OFFSET;
		after_first = due && !first_kick;
		sync_ok     = after_first && reply_valid && reply_ok;
		// a bogus reply still falls through to the resend check
		resend_chk  = after_first && !sync_ok &&
			((now_ms - last_kick_q) >= 32'(regs.resend_gap_ms));
		resend      = resend_chk && (try_q < regs.try_limit);
		give_up     = resend_chk && !(try_q < regs.try_limit);

		epoch_n = sync_ok ? reply_ntp_seconds - ntpss_pkg::NTP_UNIX_OFFSET : epoch_t;
		have_n  = have_time_q || sync_ok;
		tick_n  = sync_ok ? now_ms : tick.next_tick;
		sync_n  = (sync_ok || give_up) ? now_ms : last_sync_q;
		kick_n  = ((due && first_kick) || resend) ? now_ms : last_kick_q;

		priority if (due && first_kick) begin
			try_n = 8'd1;
		end else if (sync_ok || give_up) begin
			try_n = 8'd0;
		end else if (resend) begin
			try_n = try_q + 8'd1;
		end else begin
			try_n = try_q;
		end

		result.send_request = (due && first_kick) || resend;
		result.epoch_utc    = epoch_n;
		result.time_valid   = have_n && (epoch_n != 32'd0);
		result.synced       = sync_ok;
		result.gave_up      = give_up;
		result.bogus_reply  = after_first && reply_valid && !reply_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= '0;
			have_time_q <= 1'b0;
			last_tick_q <= '0;
			last_sync_q <= '0;
			last_kick_q <= '0;
			try_q       <= '0;
		end else if (step) begin
			epoch_q     <= epoch_n;
			have_time_q <= have_n;
			last_tick_q <= tick_n;
			last_sync_q <= sync_n;
			last_kick_q <= kick_n;
			try_q       <= try_n;
		end
	end

endmodule

@@ src/ntp_sync_sequencer_core.sv @@
// ntp sync sequencer top: poll register, decision step and result register
//
//   channel  direction  handshake            beat contents
//   in       in         in_valid / in_stall  now_ms, reply_valid, reply_ntp_seconds
//   out      out        out_valid / out_stall send_request, epoch_utc, time_valid,
//                                            synced, gave_up, bogus_reply
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one poll per cycle sustained unless out_stall holds; beats leave the result register
// the poll register feeds the state update and result register combinationally,
// the ms-to-seconds reciprocal multiply being the long path
// out_stall holds the result register; in_stall rises only when both registers are full
// reset clears all sequencer state and loads the default configuration
`timescale 1ns / 1ps

module ntp_sync_sequencer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        now_ms,
	input  logic                               reply_valid,
	input  logic [31:0]                        reply_ntp_seconds,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               send_request,
	output logic [31:0]                        epoch_utc,
	output logic                               time_valid,
	output logic                               synced,
	output logic                               gave_up,
	output logic                               bogus_reply,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ntpss_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [31:0]                        cfg_data
);

	logic        valid_s1;
	logic [31:0] now_ms_s1;
	logic        reply_valid_s1;
	logic [31:0] reply_secs_s1;
	logic        out_valid_q;
	ntpss_pkg::result_t result_q;

	ntpss_pkg::cfg_regs_t   regs;
	ntpss_pkg::tick_info_t  tick;
	ntpss_pkg::result_t     result;
	logic [31:0]            last_tick;
	logic                   advance;
	logic                   in_take;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	ntpss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	ntpss_tick u_tick (
		.now_ms    (now_ms_s1),
		.last_tick (last_tick),
		.tick      (tick)
	);

	ntpss_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.now_ms            (now_ms_s1),
		.reply_valid       (reply_valid_s1),
		.reply_ntp_seconds (reply_secs_s1),
		.regs              (regs),
		.tick              (tick),
		.last_tick         (last_tick),
		.result            (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_ms_s1      <= now_ms;
			reply_valid_s1 <= reply_valid;
			reply_secs_s1  <= reply_ntp_seconds;
		end
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign send_request = result_q.send_request;
	assign epoch_utc    = result_q.epoch_utc;
	assign time_valid   = result_q.time_valid;
	assign synced       = result_q.synced;
	assign gave_up      = result_q.gave_up;
	assign bogus_reply  = result_q.bogus_reply;

`ifndef ASSERT_OFF
	// input side only backs up when a finished beat is held on the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("in_stall without a held output beat");

	// an accepted reply ends the cycle: no request, give-up or discard alongside
	a_sync_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && synced) |-> (!send_request && !gave_up && !bogus_reply))
		else $error("synced beat carries another action");

	// giving up never also sends a request
	a_giveup_nosend: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gave_up) |-> !send_request)
		else $error("gave_up together with send_request");

	// valid time always reports a nonzero epoch
	a_time_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && time_valid) |-> (epoch_utc != 32'd0))
		else $error("time_valid with zero epoch");
`endif

endmodule

@@ sim/ntp_sync_sequencer_core_tb.sv @@
// self-checking testbench for the ntp sync sequencer core
`timescale 1ns / 1ps

module ntp_sync_sequencer_core_tb;

	localparam logic [31:0] MS_PER_SEC  = 32'd1000;
	localparam int          QUIET_LIMIT = 3000;
	localparam logic [31:0] NTP_OFS     = ntpss_pkg::NTP_UNIX_OFFSET;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        reply_valid;
		logic [31:0] reply_ntp_seconds;
	} poll_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] now_ms = '0;
	logic        reply_valid = 1'b0;
	logic [31:0] reply_ntp_seconds = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        send_request;
	logic [31:0] epoch_utc;
	logic        time_valid;
	logic        synced;
	logic        gave_up;
	logic        bogus_reply;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	ntpss_pkg::cfg_reg_t cfg_index = ntpss_pkg::REG_SYNC_ENABLE;
	logic [31:0] cfg_data = '0;

	ntp_sync_sequencer_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.now_ms            (now_ms),
		.reply_valid       (reply_valid),
		.reply_ntp_seconds (reply_ntp_seconds),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.send_request      (send_request),
		.epoch_utc         (epoch_utc),
		.time_valid        (time_valid),
		.synced            (synced),
		.gave_up           (gave_up),
		.bogus_reply       (bogus_reply),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// shadow configuration
	logic        en_sync     = ntpss_pkg::RST_SYNC_ENABLE;
	logic [31:0] resync_ms   = ntpss_pkg::RST_RESYNC_INTERVAL;
	logic [7:0]  try_limit   = ntpss_pkg::RST_MAX_TRIES;
	logic [15:0] kick_gap_ms = ntpss_pkg::RST_FIRST_KICK_GAP;
	logic [15:0] resend_ms   = ntpss_pkg::RST_RESEND_GAP;

	// shadow sequencer state
	logic [31:0] clk_secs     = '0;
	logic        time_known   = 1'b0;
	logic [31:0] tick_mark_ms = '0;
	logic [31:0] sync_mark_ms = '0;
	logic [31:0] kick_mark_ms = '0;
	logic [7:0]  attempts     = '0;

	poll_t       poll_q[$];
	ntpss_pkg::result_t expected_q[$];
	logic [31:0] poll_clock = '0;
	int          polls_pushed = 0;
	int          polls_taken = 0;
	int          results_seen = 0;
	int          fail_count = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ntpss_pkg::result_t advance_sequencer(poll_t p);
		ntpss_pkg::result_t r;
		logic [31:0] elapsed;
		logic [31:0] whole_secs;
		logic        served;
		r = '0;
		elapsed = p.now_ms - tick_mark_ms;
		if (elapsed >= MS_PER_SEC) begin
			whole_secs = elapsed / MS_PER_SEC;
			if (time_known)
				clk_secs = clk_secs + whole_secs;
			tick_mark_ms = tick_mark_ms + whole_secs * MS_PER_SEC;
		end
		if (en_sync && (!time_known || (p.now_ms - sync_mark_ms) >= resync_ms)) begin
			served = 1'b0;
			if (attempts == 8'd0 && (p.now_ms - kick_mark_ms) >= {16'd0, kick_gap_ms}) begin
				r.send_request = 1'b1;
				kick_mark_ms = p.now_ms;
				attempts = 8'd1;
				served = 1'b1;
			end
			if (!served && p.reply_valid) begin
				if (p.reply_ntp_seconds < NTP_OFS) begin
					r.bogus_reply = 1'b1;
				end else begin
					clk_secs = p.reply_ntp_seconds - NTP_OFS;
					time_known = 1'b1;
					sync_mark_ms = p.now_ms;
					tick_mark_ms = p.now_ms;
					attempts = 8'd0;
					r.synced = 1'b1;
					served = 1'b1;
				end
			end
			if (!served && (p.now_ms - kick_mark_ms) >= {16'd0, resend_ms}) begin
				if (attempts < try_limit) begin
					r.send_request = 1'b1;
					attempts = attempts + 8'd1;
					kick_mark_ms = p.now_ms;
				end else begin
					r.gave_up = 1'b1;
					attempts = 8'd0;
					sync_mark_ms = p.now_ms;
				end
			end
		end
		r.epoch_utc = clk_secs;
		r.time_valid = time_known && (clk_secs != 32'd0);
		return r;
	endfunction

	// poll driver
	always @(posedge clk) begin : drive_polls
		poll_t taken;
		poll_t nxt;
		logic  hold_back;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken.now_ms = now_ms;
				taken.reply_valid = reply_valid;
				taken.reply_ntp_seconds = reply_ntp_seconds;
				expected_q.push_back(advance_sequencer(taken));
				polls_taken++;
			end
			if (!in_valid || !in_stall) begin
				// no gaps while polls 300..399 go in
				hold_back = (polls_taken < 300 || polls_taken >= 400) &&
					($urandom_range(0, 99) < 34);
				if (poll_q.size() != 0 && !hold_back) begin
					nxt = poll_q.pop_front();
					in_valid <= 1'b1;
					now_ms <= nxt.now_ms;
					reply_valid <= nxt.reply_valid;
					reply_ntp_seconds <= nxt.reply_ntp_seconds;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : check_results
		ntpss_pkg::result_t seen;
		ntpss_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.send_request = send_request;
				seen.epoch_utc = epoch_utc;
				seen.time_valid = time_valid;
				seen.synced = synced;
				seen.gave_up = gave_up;
				seen.bogus_reply = bogus_reply;
				results_seen++;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("result beat %0d arrived with nothing pending", results_seen);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (seen.send_request !== want.send_request ||
						seen.epoch_utc !== want.epoch_utc ||
						seen.time_valid !== want.time_valid ||
						seen.synced !== want.synced ||
						seen.gave_up !== want.gave_up ||
						seen.bogus_reply !== want.bogus_reply) begin
						if (fail_count < 10) begin
							$display("result beat %0d mismatch: exp send=%0b epoch=%0d %s",
								results_seen, want.send_request, want.epoch_utc,
								$sformatf("tv=%0b sync=%0b gave=%0b bogus=%0b",
								want.time_valid, want.synced, want.gave_up,
								want.bogus_reply));
							$display("  got send=%0b epoch=%0d tv=%0b sync=%0b gave=%0b bogus=%0b",
								seen.send_request, seen.epoch_utc, seen.time_valid,
								seen.synced, seen.gave_up, seen.bogus_reply);
						end
						fail_count++;
					end
				end
				// one long backpressure stretch so the block fills and stalls its input
				if (results_seen == 150)
					hold_left = 120;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (results_seen < 300 || results_seen >= 400) &&
					($urandom_range(0, 99) < 34);
			end
		end
	end

	// watchdog on cycles with no beat anywhere
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(ntpss_pkg::cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ntpss_pkg::REG_SYNC_ENABLE:     en_sync = val[0];
			ntpss_pkg::REG_RESYNC_INTERVAL: resync_ms = val;
			ntpss_pkg::REG_MAX_TRIES:       try_limit = val[7:0];
			ntpss_pkg::REG_FIRST_KICK_GAP:  kick_gap_ms = val[15:0];
			ntpss_pkg::REG_RESEND_GAP:      resend_ms = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic en, logic [31:0] resync, logic [7:0] tries,
		logic [15:0] first_gap, logic [15:0] resend_gap);
		write_reg(ntpss_pkg::REG_SYNC_ENABLE, {31'd0, en});
		write_reg(ntpss_pkg::REG_RESYNC_INTERVAL, resync);
		write_reg(ntpss_pkg::REG_MAX_TRIES, {24'd0, tries});
		write_reg(ntpss_pkg::REG_FIRST_KICK_GAP, {16'd0, first_gap});
		write_reg(ntpss_pkg::REG_RESEND_GAP, {16'd0, resend_gap});
		cfg_valid <= 1'b0;
	endtask

	// wait until every pushed poll has its result out, then let the pipe settle
	task automatic drain;
		while (results_seen < polls_pushed)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_poll(logic [31:0] t, logic rv, logic [31:0] secs);
		poll_t p;
		p.now_ms = t;
		p.reply_valid = rv;
		p.reply_ntp_seconds = secs;
		poll_q.push_back(p);
		polls_pushed++;
		poll_clock = t;
	endtask

	task automatic push_random_polls(int count, logic [31:0] short_ms, logic [31:0] long_ms);
		logic [31:0] step;
		logic [31:0] secs;
		int          pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				step = $urandom_range(0, 60);
			else if (pick < 85)
				step = $urandom_range(0, short_ms);
			else if (pick < 97)
				step = $urandom_range(0, long_ms);
			else
				step = $urandom();
			pick = $urandom_range(0, 99);
			if (pick < 80)
				secs = $urandom_range(NTP_OFS, 32'hFFFF_FFFF);
			else if (pick < 95)
				secs = $urandom_range(0, NTP_OFS - 32'd1);
			else
				secs = $urandom();
			push_poll(poll_clock + step, $urandom_range(0, 99) < 30, secs);
		end
	endtask

	initial begin : run
		logic [31:0] b;
		logic [15:0] g1;
		logic [15:0] g2;
		// disabled at reset: replies are ignored, epoch not yet known
		push_poll(32'd0, 1'b1, 32'hFFFF_FFFF);
		push_poll(32'd1500, 1'b1, NTP_OFS);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		drain;

		// first request, bogus reply, resend, give-up, sync to epoch zero, resync
		set_config(1'b1, 32'd2000, 8'd2, 16'd50, 16'd100);
		b = 32'd2000;
		push_poll(b + 32'd100, 1'b1, NTP_OFS + 32'd5);
		push_poll(b + 32'd150, 1'b1, NTP_OFS - 32'd1);
		push_poll(b + 32'd200, 1'b0, 32'd0);
		push_poll(b + 32'd300, 1'b0, 32'd0);
		push_poll(b + 32'd350, 1'b0, 32'd0);
		push_poll(b + 32'd360, 1'b1, NTP_OFS);
		push_poll(b + 32'd1360, 1'b0, 32'd0);
		push_poll(b + 32'd2400, 1'b1, 32'hFFFF_FFFF);
		push_poll(b + 32'd2410, 1'b1, 32'hFFFF_FFFF);
		push_poll(b + 32'd2420, 1'b1, 32'd0);
		drain;

		// zero tries and zero interval, then a millisecond wrap
		set_config(1'b1, 32'd0, 8'd0, 16'd0, 16'd0);
		push_poll(32'd5000, 1'b0, 32'd0);
		push_poll(32'd5000, 1'b0, 32'd0);
		push_poll(32'd5001, 1'b1, 32'd0);
		push_poll(32'd5001, 1'b1, 32'd0);
		push_poll(32'd5002, 1'b1, NTP_OFS + 32'd100);
		push_poll(32'd5003, 1'b1, NTP_OFS + 32'd100);
		push_poll(32'hFFFF_FFF0, 1'b1, NTP_OFS + 32'd7);
		push_poll(32'h0000_0200, 1'b1, NTP_OFS + 32'd9);
		drain;

		set_config(1'b1, 32'd3000, 8'd3, 16'd50, 16'd400);
		push_random_polls(150, 32'd900, 32'd9000);
		drain;

		// widest settings; one poll lands exactly a full interval after the last sync
		set_config(1'b1, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 16'hFFFF);
		push_poll(sync_mark_ms - 32'd1, 1'b0, $urandom());
		push_random_polls(80, 32'd140000, 32'hFFFF_FFFF);
		drain;

		set_config(1'b1, 32'd1, 8'd1, 16'd0, 16'd0);
		push_random_polls(100, 32'd50, 32'd100);
		drain;

		set_config(1'b0, 32'd5000, 8'd2, 16'd10, 16'd20);
		push_random_polls(60, 32'd60, 32'd15000);
		drain;

		g1 = 16'($urandom_range(0, 300));
		g2 = 16'($urandom_range(0, 1000));
		set_config(1'b1, $urandom_range(1, 20000), 8'($urandom_range(1, 6)), g1, g2);
		push_random_polls(140, 2 * ((g1 > g2) ? g1 : g2) + 32'd2, 3 * resync_ms);
		drain;

		// sync to the latest possible epoch, then let it tick on with sequencing off
		set_config(1'b1, 32'd0, 8'd3, 16'd0, 16'd400);
		push_poll(poll_clock, 1'b1, 32'hFFFF_FFFF);
		push_poll(poll_clock, 1'b1, 32'hFFFF_FFFF);
		drain;
		set_config(1'b0, 32'd3600000, 8'd3, 16'd50, 16'd400);
		for (int k = 0; k < 10; k++)
			push_poll(poll_clock + $urandom_range(32'd4200000000, 32'd4294960000),
				1'($urandom_range(0, 1)), $urandom());
		drain;

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
